@@ hw/rtl/gptsc_pkg.sv @@
// shared types and constants for the gyro phased turn steering controller
`timescale 1ns / 1ps

package gptsc_pkg;

  // datapath widths
  localparam int HeadingW = 32;
  localparam int TargetW  = 32;
  localparam int RateW    = 16;
  localparam int QuantW   = 8;
  localparam int CmdW     = 16;
  localparam int SpeedW   = 6;
  localparam int PhaseW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // divide by 500: floor(m * Recip500 / 2^Recip500Sh) is exact for m <= 32768
  localparam logic [RateW-1:0] Recip500   = 16'd33555;
  localparam int               Recip500Sh = 24;

  // steering and speed constants
  localparam logic [CmdW-1:0]   OpenLoopOfs = 16'd300;
  localparam logic [CmdW-1:0]   CounterOfs  = 16'd200;
  localparam logic [SpeedW-1:0] SpeedCount  = 6'd40;
  localparam logic [SpeedW-1:0] SpeedNear   = 6'd10;

  // maneuver phase codes
  localparam logic [PhaseW-1:0] PhaseOpen    = 2'd0;
  localparam logic [PhaseW-1:0] PhaseCounter = 2'd1;
  localparam logic [PhaseW-1:0] PhaseClosed  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTarget   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCenter   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPropGain = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDerGain  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDeadband = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNearBand = 3'd5;

  // configuration reset values
  localparam logic signed [TargetW-1:0] TargetRst   = 32'sd1130;
  localparam logic [CmdW-1:0]           CenterRst   = 16'd0;
  localparam logic [7:0]                PropGainRst = 8'd3;
  localparam logic [7:0]                DerGainRst  = 8'd10;
  localparam logic [15:0]               DeadbandRst = 16'd10;
  localparam logic [15:0]               NearBandRst = 16'd200;

  typedef struct packed {
    logic signed [TargetW-1:0] target_heading;
    logic [CmdW-1:0]           steer_center;
    logic [7:0]                prop_gain;
    logic [7:0]                deriv_gain;
    logic [15:0]               deadband;
    logic [15:0]               near_band;
  } cfg_t;

  // quantized rate word held in the input register
  typedef struct packed {
    logic                     valid;
    logic signed [QuantW-1:0] q;
  } quant_word_t;

  typedef struct packed {
    logic                     steer_valid;
    logic [CmdW-1:0]          steer_command;
    logic                     speed_valid;
    logic [SpeedW-1:0]        speed_target;
    logic [PhaseW-1:0]        phase;
    logic signed [HeadingW-1:0] heading;
  } result_t;

endpackage

@@ hw/rtl/gptsc_cfg_regs.sv @@
// configuration register file
`timescale 1ns / 1ps

module gptsc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gptsc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gptsc_pkg::CfgDataW-1:0]  cfg_data_i,
  output gptsc_pkg::cfg_t                 cfg_o
);

  gptsc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gptsc_pkg::CfgTarget:   cfg_d.target_heading = $signed(cfg_data_i);
        gptsc_pkg::CfgCenter:   cfg_d.steer_center   = cfg_data_i[15:0];
        gptsc_pkg::CfgPropGain: cfg_d.prop_gain      = cfg_data_i[7:0];
        gptsc_pkg::CfgDerGain:  cfg_d.deriv_gain     = cfg_data_i[7:0];
        gptsc_pkg::CfgDeadband: cfg_d.deadband       = cfg_data_i[15:0];
        gptsc_pkg::CfgNearBand: cfg_d.near_band      = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_heading <= gptsc_pkg::TargetRst;
      cfg_q.steer_center   <= gptsc_pkg::CenterRst;
      cfg_q.prop_gain      <= gptsc_pkg::PropGainRst;
      cfg_q.deriv_gain     <= gptsc_pkg::DerGainRst;
      cfg_q.deadband       <= gptsc_pkg::DeadbandRst;
      cfg_q.near_band      <= gptsc_pkg::NearBandRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/gptsc_rate_quant.sv @@
// input register with rate divide by 500 on the way in
`timescale 1ns / 1ps

module gptsc_rate_quant (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rate_valid_i,
  output logic                                rate_stall_o,
  input  logic signed [gptsc_pkg::RateW-1:0]  rate_z_i,
  input  logic                                take_i,
  output gptsc_pkg::quant_word_t              word_o
);

  logic [gptsc_pkg::RateW-1:0]   mag;
  logic [2*gptsc_pkg::RateW-1:0] prod;
  logic [gptsc_pkg::QuantW-1:0]  qmag;
  logic signed [gptsc_pkg::QuantW-1:0] q_d, q_q;
  logic valid_d, valid_q;
  logic accept;

  // truncate toward zero: divide the magnitude, then restore the sign
  assign mag  = rate_z_i[gptsc_pkg::RateW-1] ? (~rate_z_i + 1'b1) : rate_z_i;
  assign prod = mag * gptsc_pkg::Recip500;
  assign qmag = prod[gptsc_pkg::Recip500Sh +: gptsc_pkg::QuantW];
  assign q_d  = rate_z_i[gptsc_pkg::RateW-1] ? $signed(~qmag + 1'b1) : $signed(qmag);

  assign rate_stall_o = valid_q && !take_i;
  assign accept       = rate_valid_i && !rate_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_q <= q_d;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.q     = q_q;

endmodule

@@ hw/rtl/gptsc_steer_core.sv @@
// heading accumulation, phase sequencing, steering law and result register
`timescale 1ns / 1ps

module gptsc_steer_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gptsc_pkg::cfg_t         cfg_i,
  input  gptsc_pkg::quant_word_t  word_i,
  output logic                    take_o,
  output logic                    result_valid_o,
  input  logic                    result_stall_i,
  output gptsc_pkg::result_t      result_o
);

  localparam int ErrW = gptsc_pkg::HeadingW + 1;
  localparam int CmpW = gptsc_pkg::HeadingW + 5;

  logic signed [gptsc_pkg::HeadingW-1:0] acc_q, acc_d;
  logic [gptsc_pkg::PhaseW-1:0] phase_q, phase_d, phase_mid;
  logic signed [gptsc_pkg::QuantW-1:0] prev_q, prev_d;
  logic near_q, near_d;
  logic out_valid_q, out_valid_d;
  gptsc_pkg::result_t res_q, res_d;
  logic fire;

  logic signed [ErrW-1:0] err;
  logic [ErrW-1:0]        aerr;
  logic signed [CmpW-1:0] h_x, t_x, h3, h9, t3, t8, t9;
  logic                   cross1, cross2, near_hit, closed_upd;
  logic [gptsc_pkg::CmdW-1:0] err_lo, prev_x, p_term, d_term, corr;

  assign take_o = !out_valid_q || !result_stall_i;
  assign fire   = word_i.valid && take_o;

  assign acc_d = acc_q + {{(gptsc_pkg::HeadingW-gptsc_pkg::QuantW){word_i.q[gptsc_pkg::QuantW-1]}},
                          word_i.q};

  // exact error and its magnitude
  assign err  = ErrW'(cfg_i.target_heading) - ErrW'(acc_d);
  assign aerr = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);

  // h > trunc(T/3): 3h > T for T >= 0, 3h >= T+3 for T < 0
  // h > trunc(8T/9): 9h > 8T for T >= 0, 9h >= 8T+9 for T < 0
  assign h_x = CmpW'(acc_d);
  assign t_x = CmpW'(cfg_i.target_heading);
  assign h3  = (h_x <<< 1) + h_x;
  assign h9  = (h_x <<< 3) + h_x;
  assign t3  = t_x + CmpW'(3);
  assign t8  = t_x <<< 3;
  assign t9  = t8 + CmpW'(9);
  assign cross1 = t_x[CmpW-1] ? (h3 >= t3) : (h3 > t_x);
  assign cross2 = t_x[CmpW-1] ? (h9 >= t9) : (h9 > t8);

  always_comb begin
    phase_mid = phase_q;
    if (phase_q == gptsc_pkg::PhaseOpen && cross1) begin
      phase_mid = gptsc_pkg::PhaseCounter;
    end
    phase_d = phase_mid;
    if (phase_mid == gptsc_pkg::PhaseCounter && cross2) begin
      phase_d = gptsc_pkg::PhaseClosed;
    end
  end

  // only the low bits of the correction reach the command
  assign err_lo = err[gptsc_pkg::CmdW-1:0];
  assign prev_x = {{(gptsc_pkg::CmdW-gptsc_pkg::QuantW){prev_q[gptsc_pkg::QuantW-1]}}, prev_q};
  assign p_term = gptsc_pkg::CmdW'(cfg_i.prop_gain * err_lo);
  assign d_term = gptsc_pkg::CmdW'(cfg_i.deriv_gain * prev_x);
  assign corr   = p_term + d_term;

  assign closed_upd = (aerr >= ErrW'(cfg_i.deadband));
  assign near_hit   = (aerr <= ErrW'(cfg_i.near_band));
  assign near_d     = near_q || near_hit;

  always_comb begin
    res_d               = '0;
    prev_d              = prev_q;
    res_d.phase         = phase_d;
    res_d.heading       = acc_d;
    unique case (phase_d)
      gptsc_pkg::PhaseOpen: begin
        res_d.steer_valid   = 1'b1;
        res_d.steer_command = cfg_i.steer_center - gptsc_pkg::OpenLoopOfs;
      end
      gptsc_pkg::PhaseCounter: begin
        res_d.steer_valid   = 1'b1;
        res_d.steer_command = cfg_i.steer_center + gptsc_pkg::CounterOfs;
        res_d.speed_valid   = 1'b1;
        res_d.speed_target  = gptsc_pkg::SpeedCount;
      end
      gptsc_pkg::PhaseClosed: begin
        if (closed_upd) begin
          res_d.steer_valid   = 1'b1;
          res_d.steer_command = cfg_i.steer_center - corr;
          prev_d              = word_i.q;
        end
      end
      default: ;
    endcase
    if (near_d) begin
      res_d.speed_valid  = 1'b1;
      res_d.speed_target = gptsc_pkg::SpeedNear;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = word_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      phase_q     <= gptsc_pkg::PhaseOpen;
      prev_q      <= '0;
      near_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        acc_q   <= acc_d;
        phase_q <= phase_d;
        prev_q  <= prev_d;
        near_q  <= near_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = res_q;

  // the phase never takes the unused code
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("phase register holds unused code");

  // closed loop is final until reset
  a_phase_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == gptsc_pkg::PhaseClosed |=> phase_q == gptsc_pkg::PhaseClosed)
    else $error("phase left closed loop");

  // near flag only sets
  a_near_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    near_q |=> near_q)
    else $error("near flag cleared");

  // a delivered speed is one of the two targets (the slow one once near)
  a_speed_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.speed_valid |->
      (res_q.speed_target == gptsc_pkg::SpeedCount ||
       res_q.speed_target == gptsc_pkg::SpeedNear))
    else $error("unexpected speed target");

  // the state only moves when a word is taken
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(acc_q) && $stable(phase_q) && $stable(prev_q))
    else $error("state moved without a word");

endmodule

@@ hw/rtl/gyro_phased_turn_steer_controller_unit.sv @@
// top level of the gyro phased turn steering controller
`timescale 1ns / 1ps

// a rate word passes through the input register and then the result register
// throughput: one word per cycle while result_stall_i is low; state update is a
// single pass through the core stage
// the input register takes one more word while a result waits on a stall
// reset (async, active low) clears heading, phase, previous rate and near flag,
// empties both registers and loads the configuration defaults
module gyro_phased_turn_steer_controller_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gptsc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [gptsc_pkg::CfgDataW-1:0]      cfg_data_i,
  // rate sample channel
  input  logic                                rate_valid_i,
  output logic                                rate_stall_o,
  input  logic signed [gptsc_pkg::RateW-1:0]  rate_z_i,
  // result channel
  output logic                                result_valid_o,
  input  logic                                result_stall_i,
  output logic                                steer_valid_o,
  output logic [gptsc_pkg::CmdW-1:0]          steer_command_o,
  output logic                                speed_valid_o,
  output logic [gptsc_pkg::SpeedW-1:0]        speed_target_o,
  output logic [gptsc_pkg::PhaseW-1:0]        phase_o,
  output logic signed [gptsc_pkg::HeadingW-1:0] heading_o
);

  gptsc_pkg::cfg_t        cfg;
  gptsc_pkg::quant_word_t word;
  gptsc_pkg::result_t     res;
  logic                   take;

  // register file, always ready
  gptsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // divide by 500 (reciprocal multiply) ahead of the input register
  gptsc_rate_quant u_quant (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rate_valid_i (rate_valid_i),
    .rate_stall_o (rate_stall_o),
    .rate_z_i     (rate_z_i),
    .take_i       (take),
    .word_o       (word)
  );

  // heading, phase, steering law; result register at its output
  gptsc_steer_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .word_i         (word),
    .take_o         (take),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .result_o       (res)
  );

  // unpack the result word onto its field ports
  assign steer_valid_o   = res.steer_valid;
  assign steer_command_o = res.steer_command;
  assign speed_valid_o   = res.speed_valid;
  assign speed_target_o  = res.speed_target;
  assign phase_o         = res.phase;
  assign heading_o       = res.heading;

endmodule
